/* sv/svu_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time tables of the spherical vector unit.
// No dependencies; svu_mul and spherical_vector_unit import this package.
package svu_pkg;

	localparam int STEPS   = 28;
	localparam int MUL_LAT = 4;

	typedef logic signed [63:0] word_t;
	typedef logic signed [47:0] ang_t;
	typedef logic [STEPS-1:0][47:0] atan_tab_t;

	typedef enum logic [2:0] {
		OP_TO_CART = 3'd0,
		OP_TO_SPH  = 3'd1,
		OP_ADD     = 3'd2,
		OP_DOT     = 3'd3,
		OP_ANGLE   = 3'd4
	} op_t;

	localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
	localparam ang_t PI_Q40          = ang_t'((PI_Q60 + 64'd524288) >> 20);
	localparam ang_t HALF_Q40        = PI_Q40 >>> 1;
	localparam ang_t TWO_PI_Q40      = PI_Q40 <<< 1;
	localparam logic [42:0] LEN_MAX  = '1;
	localparam word_t XYZ_MAX        = 64'sh0000_07FF_FFFF_FFFF;
	localparam word_t XYZ_MIN        = -64'sh0000_0800_0000_0000;
	localparam ang_t ANGLE_MAX       = 48'sd843314857;

	function automatic logic [63:0] umulq_c(logic [63:0] a, logic [63:0] b, int s);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p + (128'd1 << (s - 1));
		if ((p >> (64 + s)) != 128'd0) return '1;
		return 64'(p >> s);
	endfunction

	// shift-and-subtract quotient, used only while building tables
	function automatic logic [63:0] udiv_c(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] gain_calc();
		logic [63:0] p;
		logic [63:0] y;
		logic [63:0] t;
		logic [63:0] u;
		logic [63:0] w;
		p = 64'd1 << 60;
		y = 64'h26DD3B6A << 30;
		for (int i = 0; i < STEPS; i++) begin
			if (2 * i < 64) p = p + (p >> (2 * i));
		end
		for (int i = 0; i < 6; i++) begin
			t = umulq_c(y, y, 60);
			u = umulq_c(p, t, 60);
			w = (u >= (64'd3 << 60)) ? 64'd0 : (64'd3 << 60) - u;
			y = umulq_c(y, w, 61);
		end
		return y;
	endfunction

	// atan(2^-i) in Q40 from its power series
	function automatic atan_tab_t atan_calc();
		atan_tab_t tab;
		logic signed [63:0] sum;
		logic signed [63:0] t;
		int e;
		tab = '0;
		for (int i = 0; i < STEPS; i++) begin
			if (i == 0) begin
				tab[i] = 48'((PI_Q60 + (64'd1 << 21)) >> 22);
			end else begin
				sum = '0;
				for (int k = 0; k < 32; k++) begin
					e = 62 - i * (2 * k + 1);
					if (e >= 0) begin
						t = udiv_c(64'd1 << e, 64'(2 * k + 1));
						sum = ((k & 1) != 0) ? sum - t : sum + t;
					end
				end
				tab[i] = 48'((sum + 64'sd2097152) >>> 22);
			end
		end
		return tab;
	endfunction

	localparam word_t GAIN_Q60     = word_t'(gain_calc());
	localparam atan_tab_t ATAN_TAB = atan_calc();

	function automatic logic signed [31:0] to_q28(ang_t v);
		ang_t t;
		t = (v + 48'sd2048) >>> 12;
		return t[31:0];
	endfunction

	function automatic logic signed [43:0] clamp44(word_t v);
		word_t t;
		t = (v > XYZ_MAX) ? XYZ_MAX : ((v < XYZ_MIN) ? XYZ_MIN : v);
		return t[43:0];
	endfunction

	function automatic word_t abs64(word_t v);
		return (v < 0) ? -v : v;
	endfunction

endpackage

/* sv/svu_in_if.sv */
`timescale 1ns / 1ps
// Operation channel of the spherical vector unit: valid, ready and one operation.
// No dependencies.
interface svu_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic signed [43:0] in_x;
	logic signed [43:0] in_y;
	logic signed [43:0] in_z;
	logic [42:0]        in_r1;
	logic signed [31:0] in_theta1;
	logic signed [31:0] in_phi1;
	logic [42:0]        in_r2;
	logic signed [31:0] in_theta2;
	logic signed [31:0] in_phi2;

	modport source (output valid, opcode, in_x, in_y, in_z, in_r1, in_theta1, in_phi1,
		in_r2, in_theta2, in_phi2, input ready);
	modport sink (input valid, opcode, in_x, in_y, in_z, in_r1, in_theta1, in_phi1,
		in_r2, in_theta2, in_phi2, output ready);
endinterface

/* sv/svu_out_if.sv */
`timescale 1ns / 1ps
// Result channel of the spherical vector unit: valid, ready and one result.
// No dependencies.
interface svu_out_if;
	logic               valid;
	logic               ready;
	logic signed [43:0] out_x;
	logic signed [43:0] out_y;
	logic signed [43:0] out_z;
	logic [42:0]        out_r;
	logic signed [31:0] out_theta;
	logic signed [31:0] out_phi;
	logic signed [63:0] out_dot;
	logic [29:0]        out_angle;
	logic               zero_length;

	modport source (output valid, out_x, out_y, out_z, out_r, out_theta, out_phi, out_dot,
		out_angle, zero_length, input ready);
	modport sink (input valid, out_x, out_y, out_z, out_r, out_theta, out_phi, out_dot,
		out_angle, zero_length, output ready);
endinterface

/* sv/svu_mul.sv */
`timescale 1ns / 1ps
// Four-stage signed 64x64 multiplier built from 32x32 partial products.
// Gives the exact 128-bit product and the rounded, saturated Q60 or Q62 product. Uses svu_pkg.
module svu_mul (
	input  logic                clk,
	input  logic                en,
	input  logic                sh62,
	input  svu_pkg::word_t      a,
	input  svu_pkg::word_t      b,
	output svu_pkg::word_t      q,
	output logic signed [127:0] p
);
	import svu_pkg::*;

	logic [63:0]         ma_s1, mb_s1;
	logic                neg_s1, sh_s1;
	logic [63:0]         p00_s2, p01_s2, p10_s2, p11_s2;
	logic                neg_s2, sh_s2;
	logic [127:0]        prod_s3;
	logic                neg_s3, sh_s3;
	word_t               q_s4;
	logic signed [127:0] p_s4;
	logic [127:0]        rnd;
	logic [63:0]         mag;
	logic                big;

	always_comb begin
		rnd = prod_s3 + (sh_s3 ? (128'd1 << 61) : (128'd1 << 59));
		big = sh_s3 ? (rnd[127:126] != 2'd0) : (rnd[127:124] != 4'd0);
		mag = sh_s3 ? rnd[125:62] : rnd[123:60];
		if (big || mag[63]) mag = 64'h7FFF_FFFF_FFFF_FFFF;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1   <= abs64(a);
			mb_s1   <= abs64(b);
			neg_s1  <= (a < 0) != (b < 0);
			sh_s1   <= sh62;
			p00_s2  <= ma_s1[31:0] * mb_s1[31:0];
			p01_s2  <= ma_s1[31:0] * mb_s1[63:32];
			p10_s2  <= ma_s1[63:32] * mb_s1[31:0];
			p11_s2  <= ma_s1[63:32] * mb_s1[63:32];
			neg_s2  <= neg_s1;
			sh_s2   <= sh_s1;
			prod_s3 <= {64'd0, p00_s2} + {32'd0, p01_s2, 32'd0} + {32'd0, p10_s2, 32'd0}
				+ {p11_s2, 64'd0};
			neg_s3  <= neg_s2;
			sh_s3   <= sh_s2;
			q_s4    <= neg_s3 ? -word_t'(mag) : word_t'(mag);
			p_s4    <= neg_s3 ? -$signed(prod_s3) : $signed(prod_s3);
		end
	end

	assign q = q_s4;
	assign p = p_s4;
endmodule

/* sv/spherical_vector_unit.sv */
`timescale 1ns / 1ps
// Spherical vector unit: one operation in and one result out per cycle unless a stalled
// result holds the whole pipeline; fully pipelined, nothing is dropped or repeated. It is
// built from four 28-stage CORDIC chains (sine/cosine rotation, then three vectoring
// passes) and five 4-stage multiplier layers. Uses svu_pkg, the two channel interfaces
// and svu_mul.
module spherical_vector_unit (
	input logic    clk,
	input logic    arst_n,
	svu_in_if.sink   cmd,
	svu_out_if.source res
);
	import svu_pkg::*;

	localparam int N       = STEPS;
	localparam int CTL_LEN = N + 14;
	localparam int CAR_LEN = 3 * N + 11;
	localparam int LAT     = 4 * N + 27;
	localparam int NMUL    = 19;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [43:0] x;
		logic signed [43:0] y;
		logic signed [43:0] z;
		logic [42:0]        r1;
		logic [42:0]        r2;
		logic               zl;
	} ctl_t;

	typedef struct packed {
		logic [2:0]         op;
		logic               zl;
		logic               xn;
		logic               xz;
		logic               ypos;
		logic               zz;
		logic               zpos;
		logic               dneg;
		word_t              zq;
		word_t              dq;
		logic signed [43:0] ox;
		logic signed [43:0] oy;
		logic signed [43:0] oz;
		logic signed [63:0] dot;
		logic signed [31:0] phi;
		logic signed [31:0] theta;
		logic [42:0]        r;
	} car_t;

	logic               en;
	logic [LAT-1:0]     vld;

	logic signed [31:0] ang_in [4];
	ang_t               red_a [4];
	logic               red_f [4];

	word_t              rot_x_s [4][N+1];
	word_t              rot_y_s [4][N+1];
	ang_t               rot_a_s [4][N+1];
	logic               rot_f_s [4][N+1];
	word_t              cs_c [4];
	word_t              cs_s [4];
	word_t              csd_c [4][4];
	word_t              csd_s [4][4];
	ctl_t               ctl_s [CTL_LEN];

	word_t              m_a [NMUL];
	word_t              m_b [NMUL];
	word_t              m_q [NMUL];
	logic signed [127:0] m_p [NMUL];

	logic               op4_m1;
	word_t              rs [2];
	word_t              zc [2];
	word_t              zcd [2][4];
	word_t              vu [3];
	word_t              vw [3];
	word_t              vdu [3][4];
	word_t              vdw [3][4];

	logic [2:0]         op_s1;
	logic               zl_s1;
	word_t              d_s1, cx_s1, cy_s1, cz_s1;
	word_t              fx_s1, fy_s1, fz_s1;
	logic signed [43:0] ox_s1, oy_s1, oz_s1;
	logic signed [127:0] dsum_s1;

	car_t               car0;
	word_t              vx0, vy0;
	logic               op4_s1, xn0, ovf;

	word_t              vec_x_s [3][N+1];
	word_t              vec_y_s [3][N+1];
	ang_t               vec_z_s [3][N+1];
	car_t               car_s [CAR_LEN];
	car_t               car_phi, car_th, car_r;

	ang_t               phi_a, th_a, ang_a, ang_c;
	word_t              rr_t;
	logic [42:0]        rr;

	logic signed [43:0] x_d, y_d, z_d;
	logic [42:0]        r_d;
	logic signed [31:0] theta_d, phi_d;
	logic signed [63:0] dot_d;
	logic [29:0]        angle_d;
	logic               zero_d;

	logic signed [43:0] x_q, y_q, z_q;
	logic [42:0]        r_q;
	logic signed [31:0] theta_q, phi_q;
	logic signed [63:0] dot_q;
	logic [29:0]        angle_q;
	logic               zero_q;

	assign en        = !vld[LAT-1] || res.ready;
	assign cmd.ready = en;
	assign res.valid = vld[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (en) begin
			vld <= {vld[LAT-2:0], cmd.valid};
		end
	end

	// range reduction to [-pi/2, pi/2] with a sign flip
	assign ang_in[0] = cmd.in_theta1;
	assign ang_in[1] = cmd.in_phi1;
	assign ang_in[2] = cmd.in_theta2;
	assign ang_in[3] = cmd.in_phi2;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			red_a[l] = ang_t'(ang_in[l]) <<< 12;
			red_f[l] = 1'b0;
			if (red_a[l] > PI_Q40) red_a[l] = red_a[l] - TWO_PI_Q40;
			else if (red_a[l] < -PI_Q40) red_a[l] = red_a[l] + TWO_PI_Q40;
			if (red_a[l] > HALF_Q40) begin
				red_a[l] = red_a[l] - PI_Q40;
				red_f[l] = 1'b1;
			end else if (red_a[l] < -HALF_Q40) begin
				red_a[l] = red_a[l] + PI_Q40;
				red_f[l] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				rot_x_s[l][0] <= GAIN_Q60;
				rot_y_s[l][0] <= '0;
				rot_a_s[l][0] <= red_a[l];
				rot_f_s[l][0] <= red_f[l];
				for (int k = 0; k < N; k++) begin
					if (rot_a_s[l][k] >= 0) begin
						rot_x_s[l][k+1] <= rot_x_s[l][k] - (rot_y_s[l][k] >>> k);
						rot_y_s[l][k+1] <= rot_y_s[l][k] + (rot_x_s[l][k] >>> k);
						rot_a_s[l][k+1] <= rot_a_s[l][k] - $signed(ATAN_TAB[k]);
					end else begin
						rot_x_s[l][k+1] <= rot_x_s[l][k] + (rot_y_s[l][k] >>> k);
						rot_y_s[l][k+1] <= rot_y_s[l][k] - (rot_x_s[l][k] >>> k);
						rot_a_s[l][k+1] <= rot_a_s[l][k] + $signed(ATAN_TAB[k]);
					end
					rot_f_s[l][k+1] <= rot_f_s[l][k];
				end
				cs_c[l]     <= rot_f_s[l][N] ? -rot_x_s[l][N] : rot_x_s[l][N];
				cs_s[l]     <= rot_f_s[l][N] ? -rot_y_s[l][N] : rot_y_s[l][N];
				csd_c[l][0] <= cs_c[l];
				csd_s[l][0] <= cs_s[l];
				for (int k = 1; k < 4; k++) begin
					csd_c[l][k] <= csd_c[l][k-1];
					csd_s[l][k] <= csd_s[l][k-1];
				end
			end
			ctl_s[0] <= '{op: cmd.opcode, x: cmd.in_x, y: cmd.in_y, z: cmd.in_z,
				r1: cmd.in_r1, r2: cmd.in_r2,
				zl: (cmd.in_r1 == '0) || (cmd.in_r2 == '0)};
			for (int k = 1; k < CTL_LEN; k++) ctl_s[k] <= ctl_s[k-1];
		end
	end

	// multiplier layers: r*sin/cos, then times cos/sin of azimuth, then pairwise products,
	// then the two gain corrections
	genvar g;
	generate
		for (g = 0; g < NMUL; g++) begin : g_mul
			svu_mul u_mul (
				.clk  (clk),
				.en   (en),
				.sh62 ((g >= 8) && (g <= 16)),
				.a    (m_a[g]),
				.b    (m_b[g]),
				.q    (m_q[g]),
				.p    (m_p[g])
			);
		end
	endgenerate

	assign op4_m1 = ctl_s[N+5].op == OP_ANGLE;
	assign rs[0]  = op4_m1 ? csd_s[0][3] : m_q[0];
	assign zc[0]  = op4_m1 ? csd_c[0][3] : m_q[1];
	assign rs[1]  = op4_m1 ? csd_s[2][3] : m_q[2];
	assign zc[1]  = op4_m1 ? csd_c[2][3] : m_q[3];

	assign vu[0] = m_q[4];
	assign vu[1] = m_q[5];
	assign vu[2] = zcd[0][3];
	assign vw[0] = m_q[6];
	assign vw[1] = m_q[7];
	assign vw[2] = zcd[1][3];

	always_comb begin
		m_a[0]  = word_t'({21'd0, ctl_s[N+1].r1});  m_b[0]  = cs_s[0];
		m_a[1]  = word_t'({21'd0, ctl_s[N+1].r1});  m_b[1]  = cs_c[0];
		m_a[2]  = word_t'({21'd0, ctl_s[N+1].r2});  m_b[2]  = cs_s[2];
		m_a[3]  = word_t'({21'd0, ctl_s[N+1].r2});  m_b[3]  = cs_c[2];
		m_a[4]  = rs[0];      m_b[4]  = csd_c[1][3];
		m_a[5]  = rs[0];      m_b[5]  = csd_s[1][3];
		m_a[6]  = rs[1];      m_b[6]  = csd_c[3][3];
		m_a[7]  = rs[1];      m_b[7]  = csd_s[3][3];
		m_a[8]  = vu[0];      m_b[8]  = vw[0];
		m_a[9]  = vu[1];      m_b[9]  = vw[1];
		m_a[10] = vu[2];      m_b[10] = vw[2];
		m_a[11] = vu[1];      m_b[11] = vw[2];
		m_a[12] = vu[2];      m_b[12] = vw[1];
		m_a[13] = vu[2];      m_b[13] = vw[0];
		m_a[14] = vu[0];      m_b[14] = vw[2];
		m_a[15] = vu[0];      m_b[15] = vw[1];
		m_a[16] = vu[1];      m_b[16] = vw[0];
		m_a[17] = vec_x_s[0][N];  m_b[17] = GAIN_Q60;
		m_a[18] = vec_x_s[1][N];  m_b[18] = GAIN_Q60;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 2; v++) begin
				zcd[v][0] <= zc[v];
				for (int k = 1; k < 4; k++) zcd[v][k] <= zcd[v][k-1];
			end
			for (int c = 0; c < 3; c++) begin
				vdu[c][0] <= vu[c];
				vdw[c][0] <= vw[c];
				for (int k = 1; k < 4; k++) begin
					vdu[c][k] <= vdu[c][k-1];
					vdw[c][k] <= vdw[c][k-1];
				end
			end
			op_s1   <= ctl_s[N+13].op;
			zl_s1   <= ctl_s[N+13].zl;
			d_s1    <= m_q[8] + m_q[9] + m_q[10];
			cx_s1   <= m_q[11] - m_q[12];
			cy_s1   <= m_q[13] - m_q[14];
			cz_s1   <= m_q[15] - m_q[16];
			dsum_s1 <= m_p[8] + m_p[9] + m_p[10] + 128'sd32768;
			if (ctl_s[N+13].op == OP_TO_SPH) begin
				fx_s1 <= word_t'(ctl_s[N+13].x);
				fy_s1 <= word_t'(ctl_s[N+13].y);
				fz_s1 <= word_t'(ctl_s[N+13].z);
			end else begin
				fx_s1 <= vdu[0][3] + vdw[0][3];
				fy_s1 <= vdu[1][3] + vdw[1][3];
				fz_s1 <= vdu[2][3] + vdw[2][3];
			end
			ox_s1 <= clamp44(vdu[0][3]);
			oy_s1 <= clamp44(vdu[1][3]);
			oz_s1 <= clamp44(vdu[2][3]);
		end
	end

	// set up the first vectoring pass and the flags the later passes need
	always_comb begin
		op4_s1 = op_s1 == OP_ANGLE;
		xn0    = fx_s1 < 0;
		ovf    = !((&dsum_s1[127:79]) || !(|dsum_s1[127:79]));
		vx0    = op4_s1 ? abs64(cx_s1) : ((xn0 ? -fx_s1 : fx_s1) <<< 15);
		vy0    = op4_s1 ? cy_s1 : ((xn0 ? -fy_s1 : fy_s1) <<< 15);
		car0.op    = op_s1;
		car0.zl    = zl_s1;
		car0.xn    = xn0;
		car0.xz    = fx_s1 == 0;
		car0.ypos  = fy_s1 > 0;
		car0.zz    = fz_s1 == 0;
		car0.zpos  = fz_s1 > 0;
		car0.dneg  = d_s1 < 0;
		car0.zq    = op4_s1 ? abs64(cz_s1) : (abs64(fz_s1) <<< 15);
		car0.dq    = abs64(d_s1);
		car0.ox    = ox_s1;
		car0.oy    = oy_s1;
		car0.oz    = oz_s1;
		car0.dot   = ovf ? (dsum_s1[127] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF)
			: dsum_s1[79:16];
		car0.phi   = '0;
		car0.theta = '0;
		car0.r     = '0;
	end

	always_comb begin
		if (car_s[N].xz) phi_a = car_s[N].ypos ? HALF_Q40 : -HALF_Q40;
		else phi_a = car_s[N].xn ? vec_z_s[0][N] + PI_Q40 : vec_z_s[0][N];
		if (car_s[2*N+5].zz) th_a = HALF_Q40;
		else th_a = car_s[2*N+5].zpos ? vec_z_s[1][N] : PI_Q40 - vec_z_s[1][N];
		rr_t = (m_q[18] + 64'sd16384) >>> 15;
		if (rr_t < 0) rr = '0;
		else if (rr_t > word_t'({21'd0, LEN_MAX})) rr = LEN_MAX;
		else rr = rr_t[42:0];
		ang_a = car_s[3*N+10].dneg ? PI_Q40 - vec_z_s[2][N] : vec_z_s[2][N];
		ang_c = (ang_a + 48'sd2048) >>> 12;
		if (ang_c < 0) ang_c = '0;
		else if (ang_c > ANGLE_MAX) ang_c = ANGLE_MAX;
	end

	always_comb begin
		car_phi       = car_s[N];
		car_phi.phi   = to_q28(phi_a);
		car_th        = car_s[2*N+5];
		car_th.theta  = to_q28(th_a);
		car_r         = car_s[2*N+9];
		car_r.r       = rr;
	end

	always_comb begin
		x_d     = '0;
		y_d     = '0;
		z_d     = '0;
		r_d     = '0;
		theta_d = '0;
		phi_d   = '0;
		dot_d   = '0;
		angle_d = '0;
		zero_d  = 1'b0;
		case (car_s[3*N+10].op)
			OP_TO_CART: begin
				x_d = car_s[3*N+10].ox;
				y_d = car_s[3*N+10].oy;
				z_d = car_s[3*N+10].oz;
			end
			OP_TO_SPH, OP_ADD: begin
				r_d     = car_s[3*N+10].r;
				theta_d = car_s[3*N+10].theta;
				phi_d   = car_s[3*N+10].phi;
			end
			OP_DOT: begin
				dot_d = car_s[3*N+10].dot;
			end
			OP_ANGLE: begin
				if (car_s[3*N+10].zl) zero_d = 1'b1;
				else angle_d = ang_c[29:0];
			end
			default: begin
				zero_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_x_s[0][0] <= vx0;
			vec_y_s[0][0] <= vy0;
			vec_x_s[1][0] <= car_s[N+4].zq;
			vec_y_s[1][0] <= m_q[17];
			vec_x_s[2][0] <= car_s[2*N+9].dq;
			vec_y_s[2][0] <= m_q[18];
			for (int c = 0; c < 3; c++) begin
				vec_z_s[c][0] <= '0;
				for (int k = 0; k < N; k++) begin
					if (vec_y_s[c][k] >= 0) begin
						vec_x_s[c][k+1] <= vec_x_s[c][k] + (vec_y_s[c][k] >>> k);
						vec_y_s[c][k+1] <= vec_y_s[c][k] - (vec_x_s[c][k] >>> k);
						vec_z_s[c][k+1] <= vec_z_s[c][k] + $signed(ATAN_TAB[k]);
					end else begin
						vec_x_s[c][k+1] <= vec_x_s[c][k] - (vec_y_s[c][k] >>> k);
						vec_y_s[c][k+1] <= vec_y_s[c][k] + (vec_x_s[c][k] >>> k);
						vec_z_s[c][k+1] <= vec_z_s[c][k] - $signed(ATAN_TAB[k]);
					end
				end
			end
			car_s[0] <= car0;
			for (int k = 1; k < CAR_LEN; k++) begin
				if (k == N + 1) car_s[k] <= car_phi;
				else if (k == 2 * N + 6) car_s[k] <= car_th;
				else if (k == 2 * N + 10) car_s[k] <= car_r;
				else car_s[k] <= car_s[k-1];
			end

			x_q     <= x_d;
			y_q     <= y_d;
			z_q     <= z_d;
			r_q     <= r_d;
			theta_q <= theta_d;
			phi_q   <= phi_d;
			dot_q   <= dot_d;
			angle_q <= angle_d;
			zero_q  <= zero_d;
		end
	end

	assign res.out_x       = x_q;
	assign res.out_y       = y_q;
	assign res.out_z       = z_q;
	assign res.out_r       = r_q;
	assign res.out_theta   = theta_q;
	assign res.out_phi     = phi_q;
	assign res.out_dot     = dot_q;
	assign res.out_angle   = angle_q;
	assign res.zero_length = zero_q;
endmodule
